// ===== sv/assert_macros.svh =====
// assertion macros shared by the adc frame sensor monitor modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, quiet while arst_n is low
`define AFSM_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("afsm: same-cycle check failed");

// next-cycle implication, sampled on clk, quiet while arst_n is low
`define AFSM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("afsm: next-cycle check failed");

`endif

// ===== sv/afsm_pkg.sv =====
// shared types and constants of the adc frame sensor monitor
`default_nettype none

package afsm_pkg;

	// frame layout
	localparam int NUM_CH   = 6;
	localparam int SAMPLE_W = 12;
	localparam int LINES    = 4;

	// adc channel of each signal
	localparam int CH_CTRL = 0;
	localparam int CH_BL   = 1;
	localparam int CH_FL   = 2;
	localparam int CH_BR   = 3;
	localparam int CH_PWR  = 4;
	localparam int CH_FR   = 5;

	// line bit positions in the result
	localparam int BIT_FR = 0;
	localparam int BIT_FL = 1;
	localparam int BIT_BR = 2;
	localparam int BIT_BL = 3;

	// millivolt scaling, scale in 4.16 fixed point
	localparam int MV_W     = 16;
	localparam int SCALE_W  = 20;
	localparam int FRAC_W   = 16;
	localparam int MVPROD_W = SAMPLE_W + SCALE_W;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = SCALE_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WHITE_LEVEL     = 3'd0,
		REG_LINE_ENABLE     = 3'd1,
		REG_CTRL_LOW_MV     = 3'd2,
		REG_POWER_LOW_MV    = 3'd3,
		REG_CTRL_SCALE      = 3'd4,
		REG_POWER_SCALE     = 3'd5
	} afsm_reg_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] white_level;
		logic [LINES-1:0]    line_enable_mask;
		logic [MV_W-1:0]     ctrl_low_mv;
		logic [MV_W-1:0]     power_low_mv;
		logic [SCALE_W-1:0]  ctrl_scale;
		logic [SCALE_W-1:0]  power_scale;
	} afsm_cfg_t;

	localparam afsm_cfg_t CFG_RESET = '{
		white_level:      12'd1000,
		line_enable_mask: 4'd15,
		ctrl_low_mv:      16'd14920,
		power_low_mv:     16'd44760,
		ctrl_scale:       20'd301033,
		power_scale:      20'd794441
	};

	// tracked readings after reset
	localparam logic [MV_W-1:0] PREV_CTRL_MV_RESET  = 16'd16000;
	localparam logic [MV_W-1:0] PREV_POWER_MV_RESET = 16'd42000;

	// per-channel block averages
	typedef struct packed {
		logic                               valid;
		logic [NUM_CH-1:0][SAMPLE_W-1:0]    avg;
	} afsm_avg_t;

	// one result transaction
	typedef struct packed {
		logic [LINES-1:0] line_white_bits;
		logic [LINES-1:0] line_change_events;
		logic [MV_W-1:0]  ctrl_battery_mv;
		logic [MV_W-1:0]  power_battery_mv;
		logic             ctrl_battery_low;
		logic             power_battery_low;
		logic             ctrl_low_event;
		logic             power_low_event;
	} afsm_res_t;

endpackage

`default_nettype wire

// ===== sv/afsm_accum.sv =====
// per-channel frame accumulators and block counter
`default_nettype none
`include "assert_macros.svh"

module afsm_accum #(
	parameter int FRAMES = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	input  wire logic [afsm_pkg::NUM_CH-1:0][afsm_pkg::SAMPLE_W-1:0] samples,
	input  wire logic en_s2,
	output logic      blk_valid_s1,
	output logic [afsm_pkg::NUM_CH-1:0][afsm_pkg::SAMPLE_W+$clog2(FRAMES)-1:0] blk_sums_s1
);
	import afsm_pkg::*;

	localparam int SUM_W = SAMPLE_W + $clog2(FRAMES);
	localparam int CNT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam logic [CNT_W-1:0] LAST = CNT_W'(FRAMES - 1);

	logic [NUM_CH-1:0][SUM_W-1:0] sums_q;
	logic [NUM_CH-1:0][SUM_W-1:0] sums_nxt;
	logic [CNT_W-1:0]             count_q;
	logic                         last;
	logic                         acc;

	// closing frame waits only when the block register cannot be loaded
	assign last     = (count_q == LAST);
	assign in_stall = last && blk_valid_s1 && !en_s2;
	assign acc      = in_valid && !in_stall;

	// running sums including the current frame
	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			sums_nxt[i] = sums_q[i] + SUM_W'(samples[i]);
		end
	end

	// accumulators and frame counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sums_q  <= '0;
			count_q <= '0;
		end else if (acc) begin
			if (last) begin
				sums_q  <= '0;
				count_q <= '0;
			end else begin
				sums_q  <= sums_nxt;
				count_q <= count_q + 1'b1;
			end
		end
	end

	// completed block handed to the averaging stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_valid_s1 <= 1'b0;
		end else if (acc && last) begin
			blk_valid_s1 <= 1'b1;
		end else if (en_s2) begin
			blk_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && last) begin
			blk_sums_s1 <= sums_nxt;
		end
	end

	// a closing transaction always yields a block and restarts the count
	`AFSM_ASSERT_NEXT(a_block_closes, acc && last, blk_valid_s1 && (count_q == '0))

endmodule

`default_nettype wire

// ===== sv/afsm_average.sv =====
// block average per channel by multiplication with the reciprocal of the frame count
`default_nettype none

module afsm_average #(
	parameter int FRAMES = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic blk_valid_s1,
	input  wire logic [afsm_pkg::NUM_CH-1:0][afsm_pkg::SAMPLE_W+$clog2(FRAMES)-1:0] blk_sums_s1,
	input  wire logic en_s3,
	output logic      en_s2,
	output afsm_pkg::afsm_avg_t avg_s2
);
	import afsm_pkg::*;

	// round-up reciprocal, exact floor division for every sum below 2**SUM_W
	localparam int L       = $clog2(FRAMES);
	localparam int SUM_W   = SAMPLE_W + L;
	localparam int SHIFT   = SUM_W + L;
	localparam int RECIP_W = SUM_W + 1;
	localparam int PROD_W  = SUM_W + RECIP_W;
	localparam int unsigned RECIP = ((32'd1 << SHIFT) + FRAMES - 1) / FRAMES;
	localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'(RECIP);

	logic [NUM_CH-1:0][PROD_W-1:0]   prod;
	logic                            valid_s2;
	logic [NUM_CH-1:0][SAMPLE_W-1:0] avg_q_s2;

	assign en_s2 = !valid_s2 || en_s3;

	// one multiplier lane per channel
	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			prod[i] = PROD_W'(blk_sums_s1[i]) * PROD_W'(RECIP_K);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en_s2) begin
			valid_s2 <= blk_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && blk_valid_s1) begin
			for (int i = 0; i < NUM_CH; i++) begin
				avg_q_s2[i] <= prod[i][SHIFT +: SAMPLE_W];
			end
		end
	end

	assign avg_s2.valid = valid_s2;
	assign avg_s2.avg   = avg_q_s2;

endmodule

`default_nettype wire

// ===== sv/afsm_report.sv =====
// line thresholds, battery scaling, low flags, events and the result register
`default_nettype none
`include "assert_macros.svh"

module afsm_report (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire afsm_pkg::afsm_avg_t avg_s2,
	input  wire afsm_pkg::afsm_cfg_t cfg,
	output logic      en_s3,
	output logic      out_valid,
	input  wire logic out_stall,
	output afsm_pkg::afsm_res_t res
);
	import afsm_pkg::*;

	logic                 valid_s3;
	logic [LINES-1:0]     white_s3;
	logic [MVPROD_W-1:0]  cprod_s3;
	logic [MVPROD_W-1:0]  pprod_s3;
	logic [LINES-1:0]     white;
	logic                 en_out;
	logic [MV_W-1:0]      cmv;
	logic [MV_W-1:0]      pmv;
	logic                 clow;
	logic                 plow;
	logic                 out_valid_q;
	afsm_res_t            res_q;
	logic [LINES-1:0]     prev_white_q;
	logic [MV_W-1:0]      prev_ctrl_q;
	logic [MV_W-1:0]      prev_power_q;

	assign en_out = !out_valid_q || !out_stall;
	assign en_s3  = !valid_s3 || en_out;

	// white when the average sits below the threshold
	always_comb begin
		white         = '0;
		white[BIT_FR] = avg_s2.avg[CH_FR] < cfg.white_level;
		white[BIT_FL] = avg_s2.avg[CH_FL] < cfg.white_level;
		white[BIT_BR] = avg_s2.avg[CH_BR] < cfg.white_level;
		white[BIT_BL] = avg_s2.avg[CH_BL] < cfg.white_level;
	end

	// stage 3: white bits and millivolt products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en_s3) begin
			valid_s3 <= avg_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && avg_s2.valid) begin
			white_s3 <= white;
			cprod_s3 <= MVPROD_W'(avg_s2.avg[CH_CTRL]) * MVPROD_W'(cfg.ctrl_scale);
			pprod_s3 <= MVPROD_W'(avg_s2.avg[CH_PWR]) * MVPROD_W'(cfg.power_scale);
		end
	end

	// 12 by 20 bit product shifted by 16 never exceeds 16 bits, so no clamp is needed
	assign cmv  = cprod_s3[FRAC_W +: MV_W];
	assign pmv  = pprod_s3[FRAC_W +: MV_W];
	assign clow = (cmv <= cfg.ctrl_low_mv);
	assign plow = (pmv <= cfg.power_low_mv);

	// result register and tracked readings
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			prev_white_q <= '0;
			prev_ctrl_q  <= PREV_CTRL_MV_RESET;
			prev_power_q <= PREV_POWER_MV_RESET;
		end else if (en_out) begin
			out_valid_q <= valid_s3;
			if (valid_s3) begin
				prev_white_q <= white_s3;
				prev_ctrl_q  <= cmv;
				prev_power_q <= pmv;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && valid_s3) begin
			res_q.line_white_bits    <= white_s3 & cfg.line_enable_mask;
			res_q.line_change_events <= (white_s3 ^ prev_white_q) & cfg.line_enable_mask;
			res_q.ctrl_battery_mv    <= cmv;
			res_q.power_battery_mv   <= pmv;
			res_q.ctrl_battery_low   <= clow;
			res_q.power_battery_low  <= plow;
			res_q.ctrl_low_event     <= (prev_ctrl_q > cfg.ctrl_low_mv) && clow;
			res_q.power_low_event    <= (prev_power_q > cfg.power_low_mv) && plow;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

	// a crossing event is only reported together with the low flag
	`AFSM_ASSERT_IMP(a_ctrl_event_low, out_valid_q && res_q.ctrl_low_event, res_q.ctrl_battery_low)
	`AFSM_ASSERT_IMP(a_power_event_low, out_valid_q && res_q.power_low_event, res_q.power_battery_low)
	// tracked readings follow the result just loaded
	`AFSM_ASSERT_NEXT(a_prev_tracks, en_out && valid_s3,
		(prev_ctrl_q == res_q.ctrl_battery_mv) && (prev_power_q == res_q.power_battery_mv))

endmodule

`default_nettype wire

// ===== sv/adc_frame_sensor_monitor_top.sv =====
// adc frame sensor monitor: configuration registers and the four-stage result path
// Throughput: one frame per clock while in_stall is low; one result per FRAMES frames.
// The closing frame's block moves in turn through the block register, reciprocal multiply,
// threshold and scale multiply and the result register, where out_valid rises.
// in_stall is raised only on a closing frame while every stage up to a stalled result is full.
// Reset (arst_n low, asynchronous): sums and frame count zero, registers at their defaults,
// tracked readings 16000 mV and 42000 mV, no line sensor white.
`default_nettype none
`include "assert_macros.svh"

module adc_frame_sensor_monitor_top #(
	parameter int FRAMES = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	// configuration write port
	input  wire logic cfg_write,
	input  wire logic [afsm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [afsm_pkg::CFG_DATA_W-1:0] cfg_data,
	// frame input
	input  wire logic in_valid,
	output logic      in_stall,
	input  wire logic [afsm_pkg::SAMPLE_W-1:0] ctrl_battery_raw,
	input  wire logic [afsm_pkg::SAMPLE_W-1:0] line_back_left_raw,
	input  wire logic [afsm_pkg::SAMPLE_W-1:0] line_front_left_raw,
	input  wire logic [afsm_pkg::SAMPLE_W-1:0] line_back_right_raw,
	input  wire logic [afsm_pkg::SAMPLE_W-1:0] power_battery_raw,
	input  wire logic [afsm_pkg::SAMPLE_W-1:0] line_front_right_raw,
	// result output
	output logic      out_valid,
	input  wire logic out_stall,
	output logic [afsm_pkg::LINES-1:0] line_white_bits,
	output logic [afsm_pkg::LINES-1:0] line_change_events,
	output logic [afsm_pkg::MV_W-1:0]  ctrl_battery_mv,
	output logic [afsm_pkg::MV_W-1:0]  power_battery_mv,
	output logic      ctrl_battery_low,
	output logic      power_battery_low,
	output logic      ctrl_low_event,
	output logic      power_low_event
);
	import afsm_pkg::*;

	localparam int SUM_W = SAMPLE_W + $clog2(FRAMES);

	afsm_cfg_t                       cfg_q;
	logic [NUM_CH-1:0][SAMPLE_W-1:0] samples;
	logic                            blk_valid_s1;
	logic [NUM_CH-1:0][SUM_W-1:0]    blk_sums_s1;
	logic                            en_s2;
	logic                            en_s3;
	afsm_avg_t                       avg_s2;
	afsm_res_t                       res;

	// configuration registers, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_WHITE_LEVEL:     cfg_q.white_level      <= cfg_data[SAMPLE_W-1:0];
				REG_LINE_ENABLE:     cfg_q.line_enable_mask <= cfg_data[LINES-1:0];
				REG_CTRL_LOW_MV:     cfg_q.ctrl_low_mv      <= cfg_data[MV_W-1:0];
				REG_POWER_LOW_MV:    cfg_q.power_low_mv     <= cfg_data[MV_W-1:0];
				REG_CTRL_SCALE:      cfg_q.ctrl_scale       <= cfg_data[SCALE_W-1:0];
				REG_POWER_SCALE:     cfg_q.power_scale      <= cfg_data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// frame in channel order
	assign samples[CH_CTRL] = ctrl_battery_raw;
	assign samples[CH_BL]   = line_back_left_raw;
	assign samples[CH_FL]   = line_front_left_raw;
	assign samples[CH_BR]   = line_back_right_raw;
	assign samples[CH_PWR]  = power_battery_raw;
	assign samples[CH_FR]   = line_front_right_raw;

	afsm_accum #(
		.FRAMES(FRAMES)
	) u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.samples      (samples),
		.en_s2        (en_s2),
		.blk_valid_s1 (blk_valid_s1),
		.blk_sums_s1  (blk_sums_s1)
	);

	afsm_average #(
		.FRAMES(FRAMES)
	) u_average (
		.clk          (clk),
		.arst_n       (arst_n),
		.blk_valid_s1 (blk_valid_s1),
		.blk_sums_s1  (blk_sums_s1),
		.en_s3        (en_s3),
		.en_s2        (en_s2),
		.avg_s2       (avg_s2)
	);

	afsm_report u_report (
		.clk       (clk),
		.arst_n    (arst_n),
		.avg_s2    (avg_s2),
		.cfg       (cfg_q),
		.en_s3     (en_s3),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res)
	);

	// result fields
	assign line_white_bits    = res.line_white_bits;
	assign line_change_events = res.line_change_events;
	assign ctrl_battery_mv    = res.ctrl_battery_mv;
	assign power_battery_mv   = res.power_battery_mv;
	assign ctrl_battery_low   = res.ctrl_battery_low;
	assign power_battery_low  = res.power_battery_low;
	assign ctrl_low_event     = res.ctrl_low_event;
	assign power_low_event    = res.power_low_event;

	// the input only waits behind a stalled result
	`AFSM_ASSERT_IMP(a_stall_from_output, in_stall, out_valid && out_stall)

endmodule

`default_nettype wire
